// File: hdl/rect_gap_distance_macros.svh
// Assertion macros for the rectangle gap distance block.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef RECT_GAP_DISTANCE_MACROS_SVH
`define RECT_GAP_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGD_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RGD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rgd_pkg.sv
// Shared types and fixed field widths for the rectangle gap distance block.
// No dependencies.
package rgd_pkg;

	localparam int FIELD_W = 32;	// width of every coordinate port
	localparam int OUT_W   = 41;	// width of the distance port

	// Control that rides along with each item through the pipeline.
	typedef struct packed {
		logic valid;
		logic manhattan;
	} rgd_ctrl_t;

endpackage

// File: hdl/rgd_gap_front.sv
// Front end: axis gaps, squares, Manhattan sum and root radicand, four stages.
// Depends on rgd_pkg.
module rgd_gap_front import rgd_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 8,
	parameter int RW          = COORD_WIDTH + 1 + FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rgd_ctrl_t          ctrl_in,
	input  logic [FIELD_W-1:0] a_left,
	input  logic [FIELD_W-1:0] a_bottom,
	input  logic [FIELD_W-1:0] a_right,
	input  logic [FIELD_W-1:0] a_top,
	input  logic [FIELD_W-1:0] b_left,
	input  logic [FIELD_W-1:0] b_bottom,
	input  logic [FIELD_W-1:0] b_right,
	input  logic [FIELD_W-1:0] b_top,
	output rgd_ctrl_t          ctrl_out,
	output logic [2*RW-1:0]    rad_out,
	output logic [RW-1:0]      man_out
);

	localparam int CW = COORD_WIDTH;

	// Sign-extend the low CW bits of a coordinate to CW+1 bits.
	function automatic logic [CW:0] sx(input logic [FIELD_W-1:0] v);
		return {v[CW-1], v[CW-1:0]};
	endfunction

	function automatic logic [CW-1:0] absv(input logic [CW:0] d);
		logic [CW:0] n;
		n = d[CW] ? (~d + 1'b1) : d;
		return n[CW-1:0];
	endfunction

	rgd_ctrl_t ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;

	logic [CW:0]      dx1_s1, dx2_s1, dy1_s1, dy2_s1;
	logic [CW-1:0]    gx_s2, gy_s2;
	logic [2*CW-1:0]  sqx_s3, sqy_s3;
	logic [CW:0]      sum_s3;
	logic [2*RW-1:0]  rad_s4;
	logic [RW-1:0]    man_s4;

	logic             ovl_x, ovl_y;
	logic [CW-1:0]    ax1, ax2, ay1, ay2, gx_d, gy_d;
	logic [2*CW:0]    sumsq;

	// Projections meet when min_a - max_b <= 0 and max_a - min_b >= 0.
	always_comb begin
		ovl_x = (dx1_s1[CW] || (dx1_s1 == '0)) && !dx2_s1[CW];
		ovl_y = (dy1_s1[CW] || (dy1_s1 == '0)) && !dy2_s1[CW];
		ax1   = absv(dx1_s1);
		ax2   = absv(dx2_s1);
		ay1   = absv(dy1_s1);
		ay2   = absv(dy2_s1);
		gx_d  = ovl_x ? '0 : ((ax1 < ax2) ? ax1 : ax2);
		gy_d  = ovl_y ? '0 : ((ay1 < ay2) ? ay1 : ay2);
		sumsq = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
		end else begin
			ctrl_s1 <= ctrl_in;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx1_s1 <= sx(a_left) - sx(b_right);
		dx2_s1 <= sx(a_right) - sx(b_left);
		dy1_s1 <= sx(a_bottom) - sx(b_top);
		dy2_s1 <= sx(a_top) - sx(b_bottom);
		gx_s2  <= gx_d;
		gy_s2  <= gy_d;
		sqx_s3 <= gx_s2 * gx_s2;
		sqy_s3 <= gy_s2 * gy_s2;
		sum_s3 <= {1'b0, gx_s2} + {1'b0, gy_s2};
		rad_s4 <= (2*RW)'(sumsq) << (2 * FRAC_BITS);
		man_s4 <= RW'(sum_s3) << FRAC_BITS;
	end

	assign ctrl_out = ctrl_s4;
	assign rad_out  = rad_s4;
	assign man_out  = man_s4;

endmodule

// File: hdl/rgd_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per item.
// Depends on rgd_pkg.
module rgd_sqrt_cell import rgd_pkg::*; #(
	parameter int RW = 41
) (
	input  logic            clk,
	input  logic            arst_n,
	input  rgd_ctrl_t       ctrl_in,
	input  logic [2*RW-1:0] rad_in,
	input  logic [RW+1:0]   rem_in,
	input  logic [RW-1:0]   root_in,
	input  logic [RW-1:0]   man_in,
	output rgd_ctrl_t       ctrl_out,
	output logic [2*RW-1:0] rad_out,
	output logic [RW+1:0]   rem_out,
	output logic [RW-1:0]   root_out,
	output logic [RW-1:0]   man_out
);

	rgd_ctrl_t         ctrl_q;
	logic [2*RW-1:0]   rad_q;
	logic [RW+1:0]     rem_q;
	logic [RW-1:0]     root_q;
	logic [RW-1:0]     man_q;

	logic [RW+1:0]     rem_sh, trial, diff;
	logic              take;

	// Bring down the next two radicand bits, try root*4+1.
	always_comb begin
		rem_sh = {rem_in[RW-1:0], rad_in[2*RW-1 -: 2]};
		trial  = {root_in, 2'b01};
		diff   = rem_sh - trial;
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		rad_q  <= {rad_in[2*RW-3:0], 2'b00};
		rem_q  <= take ? diff : rem_sh;
		root_q <= {root_in[RW-2:0], take};
		man_q  <= man_in;
	end

	assign ctrl_out = ctrl_q;
	assign rad_out  = rad_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;
	assign man_out  = man_q;

endmodule

// File: hdl/rect_gap_distance.sv
// Top level of the rectangle gap distance block: front end, root cell chain, output stage.
// Depends on rgd_pkg, rgd_gap_front, rgd_sqrt_cell and rect_gap_distance_macros.svh.
//
// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ------------------------------------------
// request   in         start & !busy          a_/b_ left, bottom, right, top; manhattan
// result    out        done (one-cycle pulse) gap_distance
//
// One item enters every cycle while busy is low; each item passes through four front-end
// stages, then the square root chain, one cell for each root bit, then the output
// register. Reset is asynchronous, active low; busy is high through reset and is
// cleared by the first clock edge after reset is released, then stays low. The
// receiver cannot stall: each result is shown for exactly one cycle.
`include "rect_gap_distance_macros.svh"

module rect_gap_distance import rgd_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [FIELD_W-1:0] a_left,
	input  logic [FIELD_W-1:0] a_bottom,
	input  logic [FIELD_W-1:0] a_right,
	input  logic [FIELD_W-1:0] a_top,
	input  logic [FIELD_W-1:0] b_left,
	input  logic [FIELD_W-1:0] b_bottom,
	input  logic [FIELD_W-1:0] b_right,
	input  logic [FIELD_W-1:0] b_top,
	input  logic               manhattan,
	output logic               done,
	output logic [OUT_W-1:0]   gap_distance
);

	// Root width: sqrt of a (2*CW+1+2*FRAC)-bit radicand; also fits the Manhattan sum.
	localparam int RW  = COORD_WIDTH + 1 + FRAC_BITS;
	localparam int EW  = (RW > OUT_W) ? RW : OUT_W;
	localparam int LAT = RW + 5;

	logic      busy_q;
	logic      accept;
	rgd_ctrl_t ctrl_in;

	// Hold busy through reset, clear it at the first clock edge after release, then drop it for good.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start && !busy_q;

	always_comb begin
		ctrl_in.valid     = accept;
		ctrl_in.manhattan = manhattan;
	end

	// Chain taps: index 0 is the front-end output, index RW the last cell.
	rgd_ctrl_t        ctrl_chain [RW+1];
	logic [2*RW-1:0]  rad_chain  [RW+1];
	logic [RW+1:0]    rem_chain  [RW+1];
	logic [RW-1:0]    root_chain [RW+1];
	logic [RW-1:0]    man_chain  [RW+1];

	rgd_gap_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS),
		.RW          (RW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (ctrl_in),
		.a_left   (a_left),
		.a_bottom (a_bottom),
		.a_right  (a_right),
		.a_top    (a_top),
		.b_left   (b_left),
		.b_bottom (b_bottom),
		.b_right  (b_right),
		.b_top    (b_top),
		.ctrl_out (ctrl_chain[0]),
		.rad_out  (rad_chain[0]),
		.man_out  (man_chain[0])
	);

	// The root and remainder start at zero for every item.
	assign rem_chain[0]  = '0;
	assign root_chain[0] = '0;

	// Advance each item one root bit per cell, most significant bit first.
	for (genvar i = 0; i < RW; i++) begin : g_cell
		rgd_sqrt_cell #(
			.RW (RW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl_in  (ctrl_chain[i]),
			.rad_in   (rad_chain[i]),
			.rem_in   (rem_chain[i]),
			.root_in  (root_chain[i]),
			.man_in   (man_chain[i]),
			.ctrl_out (ctrl_chain[i+1]),
			.rad_out  (rad_chain[i+1]),
			.rem_out  (rem_chain[i+1]),
			.root_out (root_chain[i+1]),
			.man_out  (man_chain[i+1])
		);
	end

	// Output stage: pick the mode's value, clip it to the port width.
	logic [EW-1:0]    sel_ext;
	logic [OUT_W-1:0] clipped;
	logic             done_q;
	logic [OUT_W-1:0] gap_q;

	always_comb begin
		sel_ext = ctrl_chain[RW].manhattan ? EW'(man_chain[RW]) : EW'(root_chain[RW]);
		if (sel_ext > EW'({OUT_W{1'b1}})) begin
			clipped = '1;
		end else begin
			clipped = sel_ext[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl_chain[RW].valid;
		end
	end

	always_ff @(posedge clk) begin
		gap_q <= clipped;
	end

	assign done         = done_q;
	assign gap_distance = gap_q;

	// Each accepted item is followed by a result strobe once it has passed the pipeline.
	`RGD_ASSERT(a_done_latency, clk, arst_n, accept, ##LAT done, "result strobe missing after an accepted item")
	// The final remainder stays within twice the root, so the root is the floor.
	`RGD_ASSERT(a_root_floor, clk, arst_n, ctrl_chain[RW].valid, rem_chain[RW] <= {1'b0, root_chain[RW], 1'b0}, "square root remainder out of range")
	// An item leaving the chain is shown on the next cycle.
	`RGD_ASSERT_NEXT(a_chain_to_out, clk, arst_n, ctrl_chain[RW].valid, done, "item left the chain without a result strobe")

endmodule

// File: dv/rect_gap_distance_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rect_gap_distance: directed table, then random rectangle pairs.
// Depends on rgd_pkg and the rect_gap_distance RTL; needs no files at run time.

module rect_gap_distance_tb import rgd_pkg::*;;

	// Block configuration under test (defaults of the top level)
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 8;
	localparam int LATENCY     = COORD_WIDTH + FRAC_BITS + 6;

	localparam bit [OUT_W-1:0] DIST_MAX = {OUT_W{1'b1}};

	// Mode encoding of the manhattan input
	localparam bit MODE_MANHATTAN = 1'b1;
	localparam bit MODE_EUCLID    = 1'b0;

	localparam int C_MIN = 32'sh8000_0000;
	localparam int C_MAX = 32'sh7FFF_FFFF;

	// Run control
	localparam int STALL_LIMIT   = 2000;	// cycles with no item and no result
	localparam int MAX_GAP       = 50;	// longest sender pause, cycles
	localparam int PHASE_ITEMS   = 175;
	localparam int N_PHASES      = 6;

	typedef struct {
		bit [FIELD_W-1:0] a_left, a_bottom, a_right, a_top;
		bit [FIELD_W-1:0] b_left, b_bottom, b_right, b_top;
		bit               manhattan;
	} rect_pair_t;

	// One directed row: the pair, and a hand-typed distance where it is obvious
	typedef struct {
		rect_pair_t       pair;
		bit               typed;
		bit [OUT_W-1:0]   hand_gap;
	} pair_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [FIELD_W-1:0] a_left, a_bottom, a_right, a_top;
	logic [FIELD_W-1:0] b_left, b_bottom, b_right, b_top;
	logic               manhattan;
	logic               done;
	logic [OUT_W-1:0]   gap_distance;

	bit [OUT_W-1:0] distance_q[$];	// distances still owed by the block, oldest first
	pair_row_t      directed_rows[$];
	bit [OUT_W-1:0] want_dist;

	int n_items, n_manhattan, n_zero, n_results, n_errors, stall_cycles;

	rect_gap_distance #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.a_left      (a_left),
		.a_bottom    (a_bottom),
		.a_right     (a_right),
		.a_top       (a_top),
		.b_left      (b_left),
		.b_bottom    (b_bottom),
		.b_right     (b_right),
		.b_top       (b_top),
		.manhattan   (manhattan),
		.done        (done),
		.gap_distance(gap_distance)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Distance predictor
	// ------------------------------------------------------------------

	// Gap along one axis: zero when the projections meet (touching counts),
	// else the nearer pair of facing edges. Malformed spans go through as-is.
	function automatic longint unsigned axis_gap(input longint amin, input longint amax,
		input longint bmin, input longint bmax);
		longint unsigned d_lo, d_hi;
		if (amin <= bmax && bmin <= amax)
			return 0;
		d_lo = (amin >= bmax) ? amin - bmax : bmax - amin;
		d_hi = (amax >= bmin) ? amax - bmin : bmin - amax;
		return (d_lo < d_hi) ? d_lo : d_hi;
	endfunction

	function automatic bit [OUT_W-1:0] predict_distance(input rect_pair_t p);
		longint unsigned gx, gy, gsum;
		bit [95:0]       gx_w, gy_w, sq, trial_sq;
		bit [47:0]       root, trial;
		gx = axis_gap(longint'($signed(p.a_left)), longint'($signed(p.a_right)),
			longint'($signed(p.b_left)), longint'($signed(p.b_right)));
		gy = axis_gap(longint'($signed(p.a_bottom)), longint'($signed(p.a_top)),
			longint'($signed(p.b_bottom)), longint'($signed(p.b_top)));
		if (p.manhattan == MODE_MANHATTAN) begin
			gsum = gx + gy;
			if (gsum > (DIST_MAX >> FRAC_BITS))
				return DIST_MAX;
			return OUT_W'(gsum << FRAC_BITS);
		end
		// Euclidean: exact floor of the root of the scaled sum of squares,
		// built one root bit at a time from the top
		gx_w = 96'(gx);
		gy_w = 96'(gy);
		sq   = (gx_w * gx_w + gy_w * gy_w) << (2 * FRAC_BITS);
		root = '0;
		for (int b = 47; b >= 0; b--) begin
			trial    = root | (48'd1 << b);
			trial_sq = 96'(trial) * 96'(trial);
			if (trial_sq <= sq)
				root = trial;
		end
		if (root > DIST_MAX)
			return DIST_MAX;
		return root[OUT_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	task automatic add_row(input int al, input int ab, input int ar, input int at,
		input int bl, input int bb, input int br, input int bt,
		input bit mode, input bit typed, input bit [OUT_W-1:0] hand_gap);
		pair_row_t r;
		r.pair = '{al, ab, ar, at, bl, bb, br, bt, mode};
		r.typed    = typed;
		r.hand_gap = hand_gap;
		directed_rows = {directed_rows, r};
	endtask

	// Random pair. Most are well-formed rectangles on a shared scale, so that
	// overlap, touching and small gaps all show up; some are pinned to the
	// extremes of the coordinate range; the rest is raw noise, malformed included.
	function automatic rect_pair_t random_pair();
		rect_pair_t       p;
		int unsigned      kind, w;
		bit [FIELD_W-1:0] c[8];
		bit [FIELD_W-1:0] tmp;
		kind = $urandom_range(99);
		case ($urandom_range(3))
			0: w = 4;
			1: w = 10;
			2: w = 20;
			default: w = 31;
		endcase
		for (int i = 0; i < 8; i++)
			c[i] = $signed(32'($urandom)) >>> (31 - w);
		if (kind < 85) begin
			if (kind >= 75) begin
				for (int i = 0; i < 8; i++) begin
					case ($urandom_range(4))
						0: c[i] = C_MIN;
						1: c[i] = C_MAX;
						2: c[i] = '0;
						3: c[i] = '1;
						default: ;
					endcase
				end
			end
			// order min below max on each axis of each rectangle
			for (int i = 0; i < 8; i++) begin
				if (i % 4 < 2 && $signed(c[i]) > $signed(c[i+2])) begin
					tmp = c[i];
					c[i] = c[i+2];
					c[i+2] = tmp;
				end
			end
			if (kind >= 60 && kind < 75) begin
				// butt the second rectangle against the first on one or both axes
				if ($urandom_range(1)) begin
					c[4] = c[2];
					if ($signed(c[4]) > $signed(c[6]))
						c[6] = c[4];
				end
				if ($urandom_range(1)) begin
					c[7] = c[1];
					if ($signed(c[5]) > $signed(c[7]))
						c[5] = c[7];
				end
			end
		end
		p = '{c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], 1'($urandom_range(1))};
		return p;
	endfunction

	// Present one item, hold it until taken, log what it must produce,
	// then idle for a random stretch at the given odds per cycle.
	task automatic send_pair(input rect_pair_t p, input bit typed,
		input bit [OUT_W-1:0] hand_gap, input int idle_pct);
		int gap;
		bit [OUT_W-1:0] want;
		start     <= 1'b1;
		a_left    <= p.a_left;
		a_bottom  <= p.a_bottom;
		a_right   <= p.a_right;
		a_top     <= p.a_top;
		b_left    <= p.b_left;
		b_bottom  <= p.b_bottom;
		b_right   <= p.b_right;
		b_top     <= p.b_top;
		manhattan <= p.manhattan;
		do @(posedge clk); while (busy !== 1'b0);
		want = typed ? hand_gap : predict_distance(p);
		distance_q = {distance_q, want};
		n_items++;
		if (p.manhattan == MODE_MANHATTAN)
			n_manhattan++;
		if (want == '0)
			n_zero++;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			// drop start and scramble the payload so a stray sample shows up
			start    <= 1'b0;
			a_left   <= $urandom;
			b_top    <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the sender off until the block has returned everything it owes
	task automatic drain_results();
		start <= 1'b0;
		while (distance_q.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result check and watchdog
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) begin
				if (distance_q.size() == 0) begin
					$error("gap_distance: unexpected result %0d with nothing pending",
						gap_distance);
					n_errors++;
				end else begin
					want_dist = distance_q.pop_front();
					if (gap_distance !== want_dist) begin
						$error("gap_distance mismatch: expected %0d, actual %0d",
							want_dist, gap_distance);
						n_errors++;
					end
					n_results++;
				end
			end
			if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Timeout: %0d cycles with no progress", STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	int idle_pct[N_PHASES] = '{0, 80, 0, 7, 80, 0};

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		a_left    = '0;
		a_bottom  = '0;
		a_right   = '0;
		a_top     = '0;
		b_left    = '0;
		b_bottom  = '0;
		b_right   = '0;
		b_top     = '0;
		manhattan = MODE_MANHATTAN;

		// Directed table: overlap, touching edge and corner, unit gaps, 3-4-5,
		// either side on either axis, negative coordinates, the far corners of
		// the coordinate space, malformed rectangles and alternating bit patterns
		add_row(0, 0, 10, 10, 0, 0, 10, 10, MODE_MANHATTAN, 1, 0);
		add_row(0, 0, 10, 10, 2, 3, 4, 5, MODE_EUCLID, 1, 0);
		add_row(0, 0, 10, 10, 10, 0, 20, 10, MODE_MANHATTAN, 1, 0);
		add_row(0, 0, 10, 10, 10, 10, 20, 20, MODE_EUCLID, 1, 0);
		add_row(0, 0, 10, 10, 11, 0, 20, 10, MODE_MANHATTAN, 1, 256);
		add_row(0, 0, 10, 10, 11, 0, 20, 10, MODE_EUCLID, 1, 256);
		add_row(0, 0, 10, 10, 13, 14, 20, 20, MODE_EUCLID, 1, 1280);
		add_row(0, 0, 10, 10, 13, 14, 20, 20, MODE_MANHATTAN, 1, 1792);
		add_row(100, 0, 200, 10, 0, 0, 40, 10, MODE_MANHATTAN, 1, 15360);
		add_row(-100, -100, -50, -50, -20, -100, 0, -50, MODE_MANHATTAN, 1, 7680);
		add_row(0, 100, 10, 200, 0, -5, 10, -1, MODE_EUCLID, 1, 25856);
		add_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX,
			MODE_MANHATTAN, 1, 41'h1FF_FFFF_FE00);
		add_row(C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN,
			MODE_MANHATTAN, 1, 41'h1FF_FFFF_FE00);
		add_row(C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, MODE_EUCLID, 0, 0);
		add_row(C_MIN, 0, C_MIN, 0, C_MAX, 0, C_MAX, 0, MODE_EUCLID, 1, 41'h0FF_FFFF_FF00);
		add_row(-1, -1, -1, -1, 0, 0, 0, 0, MODE_MANHATTAN, 1, 512);
		add_row(-1, -1, -1, -1, 0, 0, 0, 0, MODE_EUCLID, 0, 0);
		add_row(10, 0, 0, 5, 20, 0, 30, 5, MODE_MANHATTAN, 0, 0);
		add_row(50, 50, 0, 0, 40, 40, 30, 30, MODE_EUCLID, 0, 0);
		add_row(5, 5, -5, -5, 0, 0, 0, 0, MODE_MANHATTAN, 0, 0);
		add_row(32'h5555_5555, 32'h5555_5555, 32'h5555_5555, 32'h5555_5555,
			32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA, MODE_EUCLID, 0, 0);
		add_row(32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555,
			32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, MODE_MANHATTAN, 0, 0);
		add_row(0, 0, 0, 0, C_MAX, 1, C_MAX, 1, MODE_EUCLID, 0, 0);

		// Hold reset, then release it on an edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_pair(directed_rows[i].pair, directed_rows[i].typed,
				directed_rows[i].hand_gap, 0);
		drain_results();

		// Random phases: back to back, heavy sender idling, light idling.
		// Empty the pipeline between phases so the sender also waits on a dry block.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_pair(random_pair(), 1'b0, '0, idle_pct[ph]);
			drain_results();
		end

		// Let any stray result past the last expected one show up
		repeat (LATENCY + 10) @(posedge clk);

		$display("Covered %0d rectangle pairs: %0d Manhattan, %0d Euclidean, %0d with zero gap.",
			n_items, n_manhattan, n_items - n_manhattan, n_zero);
		$display("Checked %0d distances across back-to-back and idle-heavy traffic.", n_results);
		if (n_errors == 0 && distance_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/rgd_pkg.sv
hdl/rgd_gap_front.sv
hdl/rgd_sqrt_cell.sv
hdl/rect_gap_distance.sv
dv/rect_gap_distance_tb.sv
